// ===== sv/vst_pkg.sv =====
package vst_pkg;

   // input and result items
   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [2:0]  char_tag;
      logic        done_res;
      logic [1:0]  status;
      logic [30:0] major_value;
      logic [30:0] minor_value;
      logic [30:0] patch_value;
   } rsp_type;

   // byte classes decided by the front end
   typedef enum logic [2:0] {
      CLS_DIGIT,
      CLS_DOT,
      CLS_DASH,
      CLS_PLUS,
      CLS_LETTER,
      CLS_OTHER
   } char_class_type;

   // classified byte as it travels through the queue
   typedef struct packed {
      char_class_type cls;
      logic [3:0]     digit;
      logic           last_char;
   } tok_type;

   // parser state, encoded as the part tag
   typedef enum logic [2:0] {
      PART_MAJOR   = 3'd0,
      PART_MINOR   = 3'd1,
      PART_PATCH   = 3'd2,
      PART_UNKNOWN = 3'd3,
      PART_PRE     = 3'd4,
      PART_BUILD   = 3'd5
   } part_type;

   localparam logic [2:0] TAG_SEP     = 3'd6;
   localparam logic [2:0] TAG_IGNORED = 3'd7;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_RANGE   = 2'd2;

   localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_Z  = 8'h7A;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

endpackage

// ===== sv/version_string_tokenizer_top.sv =====
// path: a byte accepted at the input passes through the input classify register, the
// four-entry queue and the output register before its result shows on rsp_valid
// throughput: one byte per cycle unless rsp_ready holds the output; the accumulate and
// state update in the back end are done for each byte as it is taken
// reset: synchronous, active high; empties the input register, the queue and the output register and returns
// the parser to the major part with zero numbers and no error
module version_string_tokenizer_top
   import vst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    front_valid;
   logic    front_ready;
   tok_type front_tok;
   logic    queue_valid;
   logic    queue_ready;
   tok_type queue_tok;

   vst_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .tok_valid (front_valid),
      .tok_ready (front_ready),
      .tok_data  (front_tok)
   );

   vst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_tok),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_tok)
   );

   vst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (queue_valid),
      .tok_ready (queue_ready),
      .tok_data  (queue_tok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/vst_front.sv =====
module vst_front
   import vst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    tok_valid,
   input  logic    tok_ready,
   output tok_type tok_data
);

   logic    valid_ff;
   logic    valid_in;
   tok_type tok_ff;
   tok_type tok_in;
   logic    req_xfer;

   always_comb begin
      tok_in.last_char = req_data.last_char;
      tok_in.digit     = req_data.char_code[3:0];
      if (req_data.char_code >= CHAR_ZERO && req_data.char_code <= CHAR_NINE) begin
         tok_in.cls = CLS_DIGIT;
      end else if (req_data.char_code == CHAR_DOT) begin
         tok_in.cls = CLS_DOT;
      end else if (req_data.char_code == CHAR_DASH) begin
         tok_in.cls = CLS_DASH;
      end else if (req_data.char_code == CHAR_PLUS) begin
         tok_in.cls = CLS_PLUS;
      end else if ((req_data.char_code >= CHAR_UC_A && req_data.char_code <= CHAR_UC_Z) ||
                   (req_data.char_code >= CHAR_LC_A && req_data.char_code <= CHAR_LC_Z)) begin
         tok_in.cls = CLS_LETTER;
      end else begin
         tok_in.cls = CLS_OTHER;
      end
   end

   assign req_ready = !valid_ff || tok_ready;
   assign req_xfer  = req_valid && req_ready;
   assign valid_in  = req_xfer || (valid_ff && !tok_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_valid = valid_ff;
   assign tok_data  = tok_ff;

endmodule

// ===== sv/vst_queue.sv =====
module vst_queue
   import vst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  tok_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output tok_type pop_data
);

   tok_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff;
   logic [QUEUE_PTR_W:0]     count_in;
   logic                     push_xfer;
   logic                     pop_xfer;

   assign push_ready = count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push_xfer  = push_valid && push_ready;
   assign pop_xfer   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_xfer) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop_xfer) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push_xfer && !pop_xfer) begin
         count_in = count_ff + 1'b1;
      end else if (pop_xfer && !push_xfer) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_xfer) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/vst_back.sv =====
module vst_back
   import vst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    tok_valid,
   output logic    tok_ready,
   input  tok_type tok_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   part_type    part_ff;
   part_type    part_in;
   logic [30:0] major_ff;
   logic [30:0] major_in;
   logic [30:0] minor_ff;
   logic [30:0] minor_in;
   logic [30:0] patch_ff;
   logic [30:0] patch_in;
   logic [1:0]  err_ff;
   logic [1:0]  err_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;

   logic        pop;
   logic [30:0] sel_acc;
   logic [34:0] acc_x10;
   logic        acc_ovf;
   logic [30:0] acc_next;
   logic        bad;
   logic        is_alnum;
   logic [2:0]  tag;

   assign pop          = tok_valid && (!rsp_valid_ff || rsp_ready);
   assign tok_ready    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_ready);
   assign is_alnum     = tok_data.cls == CLS_DIGIT || tok_data.cls == CLS_LETTER;

   // decimal accumulate: acc * 10 + digit, saturating
   always_comb begin
      case (part_ff)
         PART_MINOR: sel_acc = minor_ff;
         PART_PATCH: sel_acc = patch_ff;
         default:    sel_acc = major_ff;
      endcase
      acc_x10  = {1'b0, sel_acc, 3'b000} + {3'b000, sel_acc, 1'b0} +
                 {31'd0, tok_data.digit};
      acc_ovf  = acc_x10 > {4'b0000, NUM_MAX};
      acc_next = acc_ovf ? NUM_MAX : acc_x10[30:0];
   end

   always_comb begin
      part_in  = part_ff;
      major_in = major_ff;
      minor_in = minor_ff;
      patch_in = patch_ff;
      err_in   = err_ff;
      tag      = TAG_IGNORED;
      bad      = 1'b0;

      if (err_ff != ST_INVALID) begin
         case (part_ff)
            PART_MAJOR, PART_MINOR, PART_PATCH: begin
               if (tok_data.cls == CLS_DIGIT) begin
                  tag = part_ff;
                  if (part_ff == PART_MAJOR) begin
                     major_in = acc_next;
                  end else if (part_ff == PART_MINOR) begin
                     minor_in = acc_next;
                  end else begin
                     patch_in = acc_next;
                  end
                  if (acc_ovf && err_ff == ST_OK) begin
                     err_in = ST_RANGE;
                  end
               end else if (tok_data.cls == CLS_DOT && part_ff != PART_PATCH) begin
                  part_in = (part_ff == PART_MAJOR) ? PART_MINOR : PART_PATCH;
                  tag     = TAG_SEP;
               end else if (tok_data.cls == CLS_DASH) begin
                  part_in = PART_PRE;
                  tag     = TAG_SEP;
               end else if (tok_data.cls == CLS_PLUS) begin
                  part_in = PART_BUILD;
                  tag     = TAG_SEP;
               end else if (tok_data.cls == CLS_LETTER) begin
                  part_in = PART_UNKNOWN;
                  tag     = PART_UNKNOWN;
               end else begin
                  bad = 1'b1;
               end
            end
            PART_UNKNOWN: begin
               if (is_alnum) begin
                  tag = PART_UNKNOWN;
               end else if (tok_data.cls == CLS_DASH) begin
                  part_in = PART_PRE;
                  tag     = TAG_SEP;
               end else if (tok_data.cls == CLS_PLUS) begin
                  part_in = PART_BUILD;
                  tag     = TAG_SEP;
               end else begin
                  bad = 1'b1;
               end
            end
            PART_PRE: begin
               if (is_alnum || tok_data.cls == CLS_DOT) begin
                  tag = PART_PRE;
               end else if (tok_data.cls == CLS_PLUS) begin
                  part_in = PART_BUILD;
                  tag     = TAG_SEP;
               end else begin
                  bad = 1'b1;
               end
            end
            PART_BUILD: begin
               if (is_alnum) begin
                  tag = PART_BUILD;
               end else begin
                  bad = 1'b1;
               end
            end
            default: begin
               bad = 1'b1;
            end
         endcase
      end

      if (bad) begin
         err_in = ST_INVALID;
         tag    = TAG_IGNORED;
      end

      rsp_in.char_tag    = tag;
      rsp_in.done_res    = tok_data.last_char;
      rsp_in.status      = err_in;
      rsp_in.major_value = tok_data.last_char ? major_in : '0;
      rsp_in.minor_value = tok_data.last_char ? minor_in : '0;
      rsp_in.patch_value = tok_data.last_char ? patch_in : '0;

      // end of string: back to the start state
      if (tok_data.last_char) begin
         part_in  = PART_MAJOR;
         major_in = '0;
         minor_in = '0;
         patch_in = '0;
         err_in   = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff      <= PART_MAJOR;
         major_ff     <= '0;
         minor_ff     <= '0;
         patch_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            part_ff  <= part_in;
            major_ff <= major_in;
            minor_ff <= minor_in;
            patch_ff <= patch_in;
            err_ff   <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/vst_checker.sv =====
module vst_checker
   import vst_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   // numbers only show on the final byte
   a_values_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.done_res |->
         rsp_data.major_value == '0 && rsp_data.minor_value == '0 &&
         rsp_data.patch_value == '0)
      else $error("numbers reported before last byte");

   // an ignored byte means the invalid-character error is set
   a_ignored_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.char_tag == TAG_IGNORED |-> rsp_data.status == ST_INVALID)
      else $error("ignored tag without invalid status");

   // invalid status is sticky until the end of the string
   a_invalid_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.status == ST_INVALID && !rsp_data.done_res
      ##1 rsp_valid |-> rsp_data.status == ST_INVALID && rsp_data.char_tag == TAG_IGNORED)
      else $error("invalid status cleared mid string");

endmodule

bind version_string_tokenizer_top vst_checker u_vst_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import vst_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 2000;
   localparam int TARGET_BYTES = 1700;
   localparam int NUM_PHASES = 6;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   version_string_tokenizer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   req_type    pending_bytes[$];
   rsp_type    expected_tokens[$];
   logic [7:0] text_buf[$];

   int bytes_queued = 0;
   int bytes_taken = 0;
   int fail_count = 0;
   int quiet_cycles = 0;
   int req_idle_max = 10;
   int rsp_idle_max = 10;
   int req_gap = 0;
   int rsp_wait = 0;
   int hold_left = 0;
   bit hold_request = 1'b0;
   bit req_taken = 1'b0;

   // predictor state
   part_type    part = PART_MAJOR;
   logic [30:0] num_major = '0;
   logic [30:0] num_minor = '0;
   logic [30:0] num_patch = '0;
   logic [1:0]  parse_status = ST_OK;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // decimal accumulate with saturation; range error only if no error yet
   function automatic logic [30:0] add_digit(input logic [30:0] acc, input logic [3:0] d);
      logic [34:0] wide;
      wide = {4'd0, acc} * 35'd10 + {31'd0, d};
      if (wide > {4'd0, NUM_MAX}) begin
         if (parse_status == ST_OK) parse_status = ST_RANGE;
         return NUM_MAX;
      end
      return wide[30:0];
   endfunction

   function automatic rsp_type tokenize_byte(input req_type r);
      rsp_type    o;
      logic [7:0] c;
      logic [2:0] tag;
      logic       bad;
      logic       is_num;
      logic       is_alpha;
      c = r.char_code;
      is_num = (c >= CHAR_ZERO && c <= CHAR_NINE);
      is_alpha = (c >= CHAR_UC_A && c <= CHAR_UC_Z) || (c >= CHAR_LC_A && c <= CHAR_LC_Z);
      tag = TAG_IGNORED;
      bad = 1'b0;
      if (parse_status != ST_INVALID) begin
         case (part)
            PART_MAJOR, PART_MINOR, PART_PATCH: begin
               if (is_num) begin
                  if (part == PART_MAJOR) num_major = add_digit(num_major, c[3:0]);
                  else if (part == PART_MINOR) num_minor = add_digit(num_minor, c[3:0]);
                  else num_patch = add_digit(num_patch, c[3:0]);
                  tag = part;
               end else if (c == CHAR_DOT && part != PART_PATCH) begin
                  part = part_type'(part + 3'd1);
                  tag = TAG_SEP;
               end else if (c == CHAR_DASH) begin
                  part = PART_PRE;
                  tag = TAG_SEP;
               end else if (c == CHAR_PLUS) begin
                  part = PART_BUILD;
                  tag = TAG_SEP;
               end else if (is_alpha) begin
                  part = PART_UNKNOWN;
                  tag = PART_UNKNOWN;
               end else begin
                  bad = 1'b1;
               end
            end
            PART_UNKNOWN: begin
               if (is_num || is_alpha) begin
                  tag = PART_UNKNOWN;
               end else if (c == CHAR_DASH) begin
                  part = PART_PRE;
                  tag = TAG_SEP;
               end else if (c == CHAR_PLUS) begin
                  part = PART_BUILD;
                  tag = TAG_SEP;
               end else begin
                  bad = 1'b1;
               end
            end
            PART_PRE: begin
               if (c == CHAR_DOT || is_num || is_alpha) begin
                  tag = PART_PRE;
               end else if (c == CHAR_PLUS) begin
                  part = PART_BUILD;
                  tag = TAG_SEP;
               end else begin
                  bad = 1'b1;
               end
            end
            PART_BUILD: begin
               if (is_num || is_alpha) tag = PART_BUILD;
               else bad = 1'b1;
            end
            default: bad = 1'b1;
         endcase
      end
      if (bad) begin
         parse_status = ST_INVALID;
         tag = TAG_IGNORED;
      end
      o.char_tag = tag;
      o.done_res = r.last_char;
      o.status = parse_status;
      o.major_value = r.last_char ? num_major : '0;
      o.minor_value = r.last_char ? num_minor : '0;
      o.patch_value = r.last_char ? num_patch : '0;
      if (r.last_char) begin
         part = PART_MAJOR;
         num_major = '0;
         num_minor = '0;
         num_patch = '0;
         parse_status = ST_OK;
      end
      return o;
   endfunction

   task automatic check_field(input string fname, input logic [30:0] want,
                              input logic [30:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
         fail_count++;
      end
   endtask

   // sender: new byte at the falling edge once the previous one is transferred
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_data <= pending_bytes.pop_front();
            req_valid <= 1'b1;
            req_gap = $urandom_range(0, req_idle_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver with per-result stall and a single long hold-off in the last phase
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      bit      moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            rsp_wait = $urandom_range(0, rsp_idle_max);
            if (expected_tokens.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_tokens.pop_front();
               check_field("char_tag", 31'(want.char_tag), 31'(rsp_data.char_tag));
               check_field("done_res", 31'(want.done_res), 31'(rsp_data.done_res));
               check_field("status", 31'(want.status), 31'(rsp_data.status));
               check_field("major_value", want.major_value, rsp_data.major_value);
               check_field("minor_value", want.minor_value, rsp_data.minor_value);
               check_field("patch_value", want.patch_value, rsp_data.patch_value);
            end
         end
         if (req_valid && req_ready) begin
            moved = 1'b1;
            req_taken = 1'b1;
            bytes_taken++;
            expected_tokens.push_back(tokenize_byte(req_data));
         end
         if (bytes_taken < bytes_queued || expected_tokens.size() > 0) begin
            if (moved) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
               $display("CHECK FAILED");
               $finish;
            end
         end
      end
   end

   task automatic add_byte(input logic [7:0] c, input logic last);
      req_type item;
      item.char_code = c;
      item.last_char = last;
      pending_bytes.push_back(item);
      bytes_queued++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] rand_alnum();
      case ($urandom_range(0, 2))
         0: return 8'(CHAR_ZERO + $urandom_range(0, 9));
         1: return 8'(CHAR_UC_A + $urandom_range(0, 25));
         default: return 8'(CHAR_LC_A + $urandom_range(0, 25));
      endcase
   endfunction

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endtask

   task automatic put_number();
      case ($urandom_range(0, 11))
         0: ;  // empty part counts as zero
         1: put_text("2147483647");
         2: put_text("2147483648");
         3: repeat ($urandom_range(9, 12))
            text_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
         default: repeat ($urandom_range(1, 3))
            text_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      endcase
   endtask

   // one string: mostly well-formed versions, some noise or a corrupted byte
   task automatic add_version();
      text_buf.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
         put_number();
         repeat ($urandom_range(0, 5) > 1 ? 2 : $urandom_range(0, 1)) begin
            text_buf.push_back(CHAR_DOT);
            put_number();
         end
         if ($urandom_range(0, 3) == 0) begin
            text_buf.push_back(8'(CHAR_LC_A + $urandom_range(0, 25)));
            repeat ($urandom_range(0, 3)) text_buf.push_back(rand_alnum());
         end
         if ($urandom_range(0, 1) == 0) begin
            text_buf.push_back(CHAR_DASH);
            repeat ($urandom_range(0, 6))
               text_buf.push_back($urandom_range(0, 4) == 0 ? CHAR_DOT : rand_alnum());
         end
         if ($urandom_range(0, 2) == 0) begin
            text_buf.push_back(CHAR_PLUS);
            repeat ($urandom_range(0, 5)) text_buf.push_back(rand_alnum());
         end
      end
      if (text_buf.size() == 0) text_buf.push_back(rand_alnum());
      if ($urandom_range(0, 7) == 0)
         text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
      foreach (text_buf[i]) add_byte(text_buf[i], i == text_buf.size() - 1);
   endtask

   initial begin
      int req_max[NUM_PHASES] = '{10, 0, 0, 10, 3, 0};
      int rsp_max[NUM_PHASES] = '{10, 0, 10, 0, 3, 0};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_text("9.9.9a-x.1+b");
      add_text("2147483648");
      add_byte(8'hFF, 1'b0);
      add_byte(8'h00, 1'b1);
      add_byte(CHAR_PLUS, 1'b1);
      while (bytes_taken < bytes_queued || expected_tokens.size() > 0) @(negedge clock);

      for (int p = 0; p < NUM_PHASES; p++) begin
         req_idle_max = req_max[p];
         rsp_idle_max = rsp_max[p];
         // long receiver hold-off while bytes keep coming
         if (p == NUM_PHASES - 1) hold_request = 1'b1;
         while (bytes_queued < (p + 1) * TARGET_BYTES / NUM_PHASES) add_version();
         while (bytes_taken < bytes_queued || expected_tokens.size() > 0) @(negedge clock);
      end

      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
